>>> rtl/core/cbsw_pkg.sv
// ----------------------------------------------------------------------------
// cbsw_pkg
// Shared types and constants for the sliding-window circuit breaker.
// ----------------------------------------------------------------------------
package cbsw_pkg;

   localparam int TIME_W    = 32;
   localparam int CFG16_W   = 16;
   localparam int WINDOW_W  = 14;
   localparam int ISO_W     = 16;
   localparam int PADDR_W   = 5;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = 3;
   localparam int FRAC_W    = 16;

   localparam logic [TIME_W-1:0] SLICE_MS = 32'd1000;

   // register reset values
   localparam logic [CFG16_W-1:0]  MIN_REQUESTS_RST    = 16'd20;
   localparam logic [CFG16_W-1:0]  ERROR_THRESHOLD_RST = 16'd32768;
   localparam logic [WINDOW_W-1:0] WINDOW_MS_RST       = 14'd10000;
   localparam logic [ISO_W-1:0]    BASE_ISOLATION_RST  = 16'd100;
   localparam logic [ISO_W-1:0]    MAX_ISOLATION_RST   = 16'd30000;

   // register indexes (byte address / 4)
   localparam logic [REG_IDX_W-1:0] REG_MIN_REQUESTS    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ERROR_THRESHOLD = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_MS       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BASE_ISOLATION  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_ISOLATION   = 3'd4;

   typedef enum logic [1:0] {
      CMD_REQUEST = 2'd0,
      CMD_SUCCESS = 2'd1,
      CMD_ERROR   = 2'd2,
      CMD_STATUS  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_CLOSED = 2'd0,
      MODE_OPEN   = 2'd1,
      MODE_HALF   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_ROLL,
      T_MUL,
      T_DECIDE
   } top_state_type;

   typedef enum logic [2:0] {
      W_IDLE,
      W_EXP_RD,
      W_EXP_CHK,
      W_NEW_RD,
      W_NEW_CHK,
      W_APPEND,
      W_POST
   } win_state_type;

   typedef struct packed {
      logic              go;
      logic [TIME_W-1:0] now_ms;
      logic              do_record;
      logic              is_error;
      logic              do_clear;
   } win_req_type;

   typedef struct packed {
      logic done;
   } win_sts_type;

endpackage

>>> rtl/core/cbsw_ram.sv
// ----------------------------------------------------------------------------
// cbsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbsw_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cbsw_window.sv
// ----------------------------------------------------------------------------
// cbsw_window
// Ring of time slices in RAM: expire old slices, open a new one, count.
// ----------------------------------------------------------------------------
module cbsw_window import cbsw_pkg::*; #(
   parameter int MAX_SLICES = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  win_req_type           win_req,
   input  logic [WINDOW_W-1:0]   window_ms,
   output win_sts_type           win_sts,
   output logic [COUNT_BITS-1:0] sum_requests,
   output logic [COUNT_BITS-1:0] sum_errors
);

   localparam int IDX_W   = $clog2(MAX_SLICES);
   localparam int CNT_W   = $clog2(MAX_SLICES + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int ENTRY_W = TIME_W + 2 * COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(MAX_SLICES)) ? (s - SUM_W'(MAX_SLICES)) : s;
      return r[IDX_W-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [COUNT_BITS-1:0] floor_sub(input logic [COUNT_BITS-1:0] a,
                                                       input logic [COUNT_BITS-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   win_state_type         state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [COUNT_BITS-1:0] sreq_ff, sreq_in, serr_ff, serr_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic                  rec_ff, rec_in, err_ff, err_in, clr_ff, clr_in;
   logic [COUNT_BITS-1:0] hreq_ff, hreq_in, herr_ff, herr_in;
   logic [IDX_W-1:0]      nidx_ff, nidx_in;
   logic [TIME_W-1:0]     nstart_ff, nstart_in;
   logic [COUNT_BITS-1:0] nreq_ff, nreq_in, nerr_ff, nerr_in;

   logic                  rd_en, wr_en;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   logic [ENTRY_W-1:0]    rd_data, wr_data;
   logic [TIME_W-1:0]     rd_start, age;
   logic [COUNT_BITS-1:0] rd_req, rd_err;
   logic [SUM_W-1:0]      head_sum;
   logic [IDX_W-1:0]      tail_idx, newest_idx, head_inc;
   logic                  expired, slice_old, ring_full, ring_empty;

   assign rd_start   = rd_data[ENTRY_W-1 -: TIME_W];
   assign rd_req     = rd_data[2*COUNT_BITS-1 -: COUNT_BITS];
   assign rd_err     = rd_data[COUNT_BITS-1:0];
   assign age        = now_ff - rd_start;
   assign expired    = age >= TIME_W'(window_ms);
   assign slice_old  = age >= SLICE_MS;
   assign head_sum   = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx   = wrap(head_sum);
   assign newest_idx = wrap(head_sum - SUM_W'(1));
   assign head_inc   = wrap(SUM_W'(head_ff) + SUM_W'(1));
   assign ring_full  = count_ff == CNT_W'(MAX_SLICES);
   assign ring_empty = count_ff == '0;

   cbsw_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_SLICES)
   ) u_slices (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: begin
            if (win_req.go) state_in = W_EXP_RD;
         end
         W_EXP_RD: begin
            state_in = ring_empty ? W_APPEND : W_EXP_CHK;
         end
         W_EXP_CHK: begin
            state_in = expired ? W_EXP_RD : W_NEW_RD;
         end
         W_NEW_RD: begin
            state_in = W_NEW_CHK;
         end
         W_NEW_CHK: begin
            state_in = slice_old ? W_APPEND : W_POST;
         end
         W_APPEND: begin
            state_in = W_POST;
         end
         W_POST: begin
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      sreq_in   = sreq_ff;
      serr_in   = serr_ff;
      now_in    = now_ff;
      rec_in    = rec_ff;
      err_in    = err_ff;
      clr_in    = clr_ff;
      hreq_in   = hreq_ff;
      herr_in   = herr_ff;
      nidx_in   = nidx_ff;
      nstart_in = nstart_ff;
      nreq_in   = nreq_ff;
      nerr_in   = nerr_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_idx;
      wr_data   = {now_ff, COUNT_BITS'(0), COUNT_BITS'(0)};
      case (state_ff)
         W_IDLE: begin
            if (win_req.go) begin
               now_in = win_req.now_ms;
               rec_in = win_req.do_record;
               err_in = win_req.is_error;
               clr_in = win_req.do_clear;
            end
         end
         W_EXP_RD: begin
            rd_en   = !ring_empty;
            rd_addr = head_ff;
         end
         W_EXP_CHK: begin
            if (expired) begin
               sreq_in  = floor_sub(sreq_ff, rd_req);
               serr_in  = floor_sub(serr_ff, rd_err);
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
            end else begin
               // keep the oldest slice's counts in case the append must evict it
               hreq_in = rd_req;
               herr_in = rd_err;
            end
         end
         W_NEW_RD: begin
            rd_en   = 1'b1;
            rd_addr = newest_idx;
         end
         W_NEW_CHK: begin
            if (!slice_old) begin
               nidx_in   = newest_idx;
               nstart_in = rd_start;
               nreq_in   = rd_req;
               nerr_in   = rd_err;
            end
         end
         W_APPEND: begin
            wr_en     = 1'b1;
            wr_addr   = tail_idx;
            nidx_in   = tail_idx;
            nstart_in = now_ff;
            nreq_in   = '0;
            nerr_in   = '0;
            if (ring_full) begin
               // full ring: tail coincides with head, evict oldest
               sreq_in = floor_sub(sreq_ff, hreq_ff);
               serr_in = floor_sub(serr_ff, herr_ff);
               head_in = head_inc;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         W_POST: begin
            if (clr_ff) begin
               head_in  = '0;
               count_in = '0;
               sreq_in  = '0;
               serr_in  = '0;
            end else if (rec_ff) begin
               wr_en   = 1'b1;
               wr_addr = nidx_ff;
               wr_data = {nstart_ff, sat_inc(nreq_ff), err_ff ? sat_inc(nerr_ff) : nerr_ff};
               sreq_in = sat_inc(sreq_ff);
               if (err_ff) serr_in = sat_inc(serr_ff);
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         sreq_ff  <= '0;
         serr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         sreq_ff  <= sreq_in;
         serr_ff  <= serr_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      rec_ff    <= rec_in;
      err_ff    <= err_in;
      clr_ff    <= clr_in;
      hreq_ff   <= hreq_in;
      herr_ff   <= herr_in;
      nidx_ff   <= nidx_in;
      nstart_ff <= nstart_in;
      nreq_ff   <= nreq_in;
      nerr_ff   <= nerr_in;
   end

   assign win_sts.done = state_ff == W_POST;
   assign sum_requests = sreq_ff;
   assign sum_errors   = serr_ff;

endmodule

>>> rtl/core/circuit_breaker_sliding_window_unit.sv
// ----------------------------------------------------------------------------
// circuit_breaker_sliding_window_unit
// Circuit breaker with a sliding error-rate window and exponential back-off.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_command / req_now_ms with start; the
//   transaction is taken on a clock edge where start is high and busy is low.
//   Commands: request permission, success report, error report, status query.
//   Result channel: one result per transaction, shown for exactly one cycle
//   with rsp_valid high. The receiver cannot hold it off.
//   Configuration: APB-style registers at byte addresses 0,4,8,12,16
//   (min_requests, error_threshold, window_ms, base/max isolation). Write
//   them only while busy is low and no result is pending.
// Timing:
//   A status query skips the ring. Reports run the slice ring in RAM (one
//   read port, one write port); requests also pass a multiply state for
//   the registered threshold product, and each expired slice dropped from
//   the ring head adds a pass through the read and check states. busy falls
//   in the cycle the result is shown, so one transaction at a time.
// Reset:
//   Synchronous. Breaker closed, ring empty, sums zero, registers at defaults.
//   Slice RAM contents are not cleared; only entries inside the ring are read.
// ----------------------------------------------------------------------------
module circuit_breaker_sliding_window_unit import cbsw_pkg::*; #(
   parameter int MAX_SLICES = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [TIME_W-1:0]  req_now_ms,
   // result channel
   output logic               rsp_valid,
   output logic               rsp_allowed,
   output logic [1:0]         rsp_circuit_state,
   output logic               rsp_is_open,
   output logic               rsp_is_available,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int PROD_W = COUNT_BITS + FRAC_W;
   localparam int CMP_W  = (COUNT_BITS > CFG16_W) ? COUNT_BITS : CFG16_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CFG16_W-1:0]   min_req_ff, thr_ff;
   logic [WINDOW_W-1:0]  window_ff;
   logic [ISO_W-1:0]     base_iso_ff, max_iso_ff;
   logic                 cfg_wr;
   logic [REG_IDX_W-1:0] cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign cfg_idx = paddr[PADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_req_ff  <= MIN_REQUESTS_RST;
         thr_ff      <= ERROR_THRESHOLD_RST;
         window_ff   <= WINDOW_MS_RST;
         base_iso_ff <= BASE_ISOLATION_RST;
         max_iso_ff  <= MAX_ISOLATION_RST;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_MIN_REQUESTS:    min_req_ff  <= pwdata[CFG16_W-1:0];
            REG_ERROR_THRESHOLD: thr_ff      <= pwdata[CFG16_W-1:0];
            REG_WINDOW_MS:       window_ff   <= pwdata[WINDOW_W-1:0];
            REG_BASE_ISOLATION:  base_iso_ff <= pwdata[ISO_W-1:0];
            REG_MAX_ISOLATION:   max_iso_ff  <= pwdata[ISO_W-1:0];
            default:             min_req_ff  <= min_req_ff;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_MIN_REQUESTS:    prdata = PDATA_W'(min_req_ff);
         REG_ERROR_THRESHOLD: prdata = PDATA_W'(thr_ff);
         REG_WINDOW_MS:       prdata = PDATA_W'(window_ff);
         REG_BASE_ISOLATION:  prdata = PDATA_W'(base_iso_ff);
         REG_MAX_ISOLATION:   prdata = PDATA_W'(max_iso_ff);
         default:             prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Breaker state and transaction sequencer
   // ---------------------------------------------------------------------
   top_state_type         state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [TIME_W-1:0]     opened_ff, opened_in;
   logic [ISO_W-1:0]      iso_ff, iso_in;
   cmd_type               cmd_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  allowed_ff, allowed_in;
   logic [1:0]            state_out_ff;
   logic                  is_open_ff, is_avail_ff, avail_in;

   win_req_type           win_req;
   win_sts_type           win_sts;
   logic [COUNT_BITS-1:0] sum_requests, sum_errors;

   logic                  accept;
   cmd_type               req_cmd;
   logic                  trip;
   logic [ISO_W:0]        iso_dbl;

   assign accept  = start && (state_ff == T_IDLE);
   assign busy    = state_ff != T_IDLE;
   assign req_cmd = cmd_type'(req_command);

   // Launch the ring update on accept; the ring only records outside half-open
   // and is wiped by a successful probe.
   always_comb begin
      win_req.go        = accept && (req_cmd != CMD_STATUS);
      win_req.now_ms    = req_now_ms;
      win_req.do_record = ((req_cmd == CMD_SUCCESS) || (req_cmd == CMD_ERROR))
                          && (mode_ff != MODE_HALF);
      win_req.is_error  = req_cmd == CMD_ERROR;
      win_req.do_clear  = (req_cmd == CMD_SUCCESS) && (mode_ff == MODE_HALF);
   end

   cbsw_window #(
      .MAX_SLICES(MAX_SLICES),
      .COUNT_BITS(COUNT_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .win_req     (win_req),
      .window_ms   (window_ff),
      .win_sts     (win_sts),
      .sum_requests(sum_requests),
      .sum_errors  (sum_errors)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) state_in = (req_cmd == CMD_STATUS) ? T_DECIDE : T_ROLL;
         end
         T_ROLL: begin
            if (win_sts.done) state_in = (cmd_ff == CMD_REQUEST) ? T_MUL : T_DECIDE;
         end
         T_MUL: begin
            state_in = T_DECIDE;
         end
         T_DECIDE: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Trip on post-roll sums: total >= min_req, errors*2^16 > threshold*total.
   assign trip = (CMP_W'(sum_requests) >= CMP_W'(min_req_ff)) &&
                 ({sum_errors, FRAC_W'(0)} > prod_ff);
   assign iso_dbl = {iso_ff, 1'b0};

   // outputs and breaker update
   always_comb begin
      mode_in      = mode_ff;
      opened_in    = opened_ff;
      iso_in       = iso_ff;
      allowed_in   = 1'b0;
      rsp_valid_in = 1'b0;
      if (state_ff == T_DECIDE) begin
         rsp_valid_in = 1'b1;
         case (cmd_ff)
            CMD_REQUEST: begin
               case (mode_ff)
                  MODE_CLOSED: begin
                     allowed_in = 1'b1;
                     if (trip) begin
                        mode_in   = MODE_OPEN;
                        opened_in = now_ff;
                     end
                  end
                  MODE_OPEN: begin
                     // isolation elapsed: let one probe through
                     if ((now_ff - opened_ff) >= TIME_W'(iso_ff)) begin
                        mode_in    = MODE_HALF;
                        allowed_in = 1'b1;
                     end
                  end
                  default: begin
                     allowed_in = 1'b0;
                  end
               endcase
            end
            CMD_SUCCESS: begin
               if (mode_ff == MODE_HALF) begin
                  mode_in = MODE_CLOSED;
                  iso_in  = base_iso_ff;
               end
            end
            CMD_ERROR: begin
               if (mode_ff == MODE_HALF) begin
                  mode_in   = MODE_OPEN;
                  opened_in = now_ff;
                  iso_in    = (iso_dbl < (ISO_W + 1)'(max_iso_ff)) ?
                              iso_dbl[ISO_W-1:0] : max_iso_ff;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
      avail_in = (mode_in != MODE_OPEN) || ((now_ff - opened_in) >= TIME_W'(iso_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         mode_ff      <= MODE_CLOSED;
         opened_ff    <= '0;
         iso_ff       <= BASE_ISOLATION_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         opened_ff    <= opened_in;
         iso_ff       <= iso_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold command, time, product and result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         now_ff <= req_now_ms;
      end
      if (state_ff == T_MUL) begin
         prod_ff <= PROD_W'(thr_ff) * PROD_W'(sum_requests);
      end
      if (rsp_valid_in) begin
         allowed_ff   <= allowed_in;
         state_out_ff <= mode_in;
         is_open_ff   <= mode_in == MODE_OPEN;
         is_avail_ff  <= avail_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allowed       = allowed_ff;
   assign rsp_circuit_state = state_out_ff;
   assign rsp_is_open       = is_open_ff;
   assign rsp_is_available  = is_avail_ff;

endmodule

>>> sim/circuit_breaker_sliding_window_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circuit_breaker_sliding_window_unit_tb
// Self-checking bench for the sliding-window circuit breaker. A short list of
// directed transactions walks the breaker through trip, probe, back-off and
// time wrap. Several register settings follow, extremes among them, each with
// a run of random command streams. Every result is compared field by field
// against the bench's cycle-free breaker model, or a hand-typed result on fixed rows.
// ----------------------------------------------------------------------------
module circuit_breaker_sliding_window_unit_tb;
   import cbsw_pkg::*;

   localparam int NUM_SLICES    = 16;
   localparam int PHASE_ITEMS   = 280;
   localparam int NUM_PHASES    = 7;
   localparam int NUM_DIRECTED  = 25;
   // Worst transaction: request plus a full ring of expired slices.
   localparam int SETTLE_CYCLES = 48;
   localparam int STALL_LIMIT   = 4000;
   localparam int PENDING_DEPTH = 8;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Result fields plus the transaction that produced them, for messages.
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] now_ms;
      logic        allowed;
      mode_type    state;
      logic        is_open;
      logic        is_available;
   } breaker_outcome_type;

   // One directed transaction; 'fixed' rows carry a hand-typed result.
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] now_ms;
      logic        fixed;
      logic        allowed;
      mode_type    state;
      logic        is_open;
      logic        is_available;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] min_req;
      logic [31:0] thr;
      logic [31:0] window;
      logic [31:0] base_iso;
      logic [31:0] max_iso;
      logic        slow;      // pace time near one slice per transaction
   } breaker_cfg_type;

   // -------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = CMD_STATUS;
   logic [TIME_W-1:0]  req_now_ms = '0;
   logic               rsp_valid;
   logic               rsp_allowed;
   logic [1:0]         rsp_circuit_state;
   logic               rsp_is_open;
   logic               rsp_is_available;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   circuit_breaker_sliding_window_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_allowed       (rsp_allowed),
      .rsp_circuit_state (rsp_circuit_state),
      .rsp_is_open       (rsp_is_open),
      .rsp_is_available  (rsp_is_available),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Breaker model state: registers, mode, isolation and the slice ring
   // -------------------------------------------------------------------------
   logic [31:0] cfg_min      = 32'(MIN_REQUESTS_RST);
   logic [31:0] cfg_thr      = 32'(ERROR_THRESHOLD_RST);
   logic [31:0] cfg_window   = 32'(WINDOW_MS_RST);
   logic [31:0] cfg_base_iso = 32'(BASE_ISOLATION_RST);
   logic [31:0] cfg_max_iso  = 32'(MAX_ISOLATION_RST);

   mode_type    brk_mode  = MODE_CLOSED;
   logic [31:0] opened_ms = '0;
   logic [31:0] iso_ms    = 32'(BASE_ISOLATION_RST);
   logic [31:0] slice_t0  [NUM_SLICES];
   logic [31:0] slice_req [NUM_SLICES];
   logic [31:0] slice_err [NUM_SLICES];
   int          ring_head  = 0;
   int          ring_count = 0;
   logic [31:0] sum_req = '0;
   logic [31:0] sum_err = '0;

   // Outstanding expected results, oldest first.
   breaker_outcome_type pending_fifo [PENDING_DEPTH];
   int                  pend_wr        = 0;
   int                  pend_rd        = 0;
   int                  mismatch_count = 0;
   int                  stall_cycles   = 0;

   // Elapsed time with modulo-2^32 wrap.
   function automatic logic [31:0] age_ms(input logic [31:0] now, input logic [31:0] since);
      return now - since;
   endfunction

   // Retire the oldest slice; sums floor at zero.
   task automatic drop_oldest_slice();
      sum_req    = (sum_req > slice_req[ring_head]) ? sum_req - slice_req[ring_head] : '0;
      sum_err    = (sum_err > slice_err[ring_head]) ? sum_err - slice_err[ring_head] : '0;
      ring_head  = (ring_head + 1) % NUM_SLICES;
      ring_count = ring_count - 1;
   endtask

   // Expire slices that fell out of the window, then open a fresh slice when
   // the ring is empty or the newest one is a full slice old.
   task automatic roll_window(input logic [31:0] now);
      int tail;
      while (ring_count > 0 && age_ms(now, slice_t0[ring_head]) >= cfg_window)
         drop_oldest_slice();
      if (ring_count == 0 ||
          age_ms(now, slice_t0[(ring_head + ring_count - 1) % NUM_SLICES]) >= SLICE_MS) begin
         if (ring_count >= NUM_SLICES)
            drop_oldest_slice();
         tail            = (ring_head + ring_count) % NUM_SLICES;
         slice_t0[tail]  = now;
         slice_req[tail] = '0;
         slice_err[tail] = '0;
         ring_count      = ring_count + 1;
      end
   endtask

   // Count a report into the newest slice and the running sums, saturating.
   task automatic count_report(input logic is_err);
      int t;
      t            = (ring_head + ring_count - 1) % NUM_SLICES;
      slice_req[t] = (slice_req[t] == COUNT_MAX) ? COUNT_MAX : slice_req[t] + 1;
      sum_req      = (sum_req == COUNT_MAX) ? COUNT_MAX : sum_req + 1;
      if (is_err) begin
         slice_err[t] = (slice_err[t] == COUNT_MAX) ? COUNT_MAX : slice_err[t] + 1;
         sum_err      = (sum_err == COUNT_MAX) ? COUNT_MAX : sum_err + 1;
      end
   endtask

   // Advance the breaker by one transaction and return its result.
   task automatic predict_breaker(input cmd_type cmd, input logic [31:0] now,
                                  output breaker_outcome_type res);
      logic [63:0] err_scaled;
      logic [63:0] thr_scaled;
      logic [31:0] doubled;
      logic        allowed;
      allowed = 1'b0;
      if (cmd != CMD_STATUS)
         roll_window(now);
      case (cmd)
         CMD_REQUEST: begin
            if (brk_mode == MODE_CLOSED) begin
               // Trip test in exact integers: errors * 2^16 against threshold * total.
               err_scaled = {16'd0, sum_err, 16'd0};
               thr_scaled = {32'd0, cfg_thr} * {32'd0, sum_req};
               if (sum_req >= cfg_min && err_scaled > thr_scaled) begin
                  brk_mode  = MODE_OPEN;
                  opened_ms = now;
               end
               allowed = 1'b1;
            end else if (brk_mode == MODE_OPEN && age_ms(now, opened_ms) >= iso_ms) begin
               brk_mode = MODE_HALF;
               allowed  = 1'b1;
            end
         end
         CMD_SUCCESS: begin
            if (brk_mode == MODE_HALF) begin
               brk_mode   = MODE_CLOSED;
               ring_head  = 0;
               ring_count = 0;
               sum_req    = '0;
               sum_err    = '0;
               iso_ms     = cfg_base_iso;
            end else begin
               count_report(1'b0);
            end
         end
         CMD_ERROR: begin
            if (brk_mode == MODE_HALF) begin
               doubled   = iso_ms * 2;
               brk_mode  = MODE_OPEN;
               opened_ms = now;
               iso_ms    = (doubled < cfg_max_iso) ? doubled : cfg_max_iso;
            end else begin
               count_report(1'b1);
            end
         end
         default: ;
      endcase
      res.cmd          = cmd;
      res.now_ms       = now;
      res.allowed      = allowed;
      res.state        = brk_mode;
      res.is_open      = (brk_mode == MODE_OPEN);
      res.is_available = (brk_mode != MODE_OPEN) || (age_ms(now, opened_ms) >= iso_ms);
   endtask

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input breaker_outcome_type w);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d (cmd %0d now_ms %h)",
                                   name, got, want, w.cmd, w.now_ms));
   endtask

   // Results cannot be held off: take each one on the edge that ends its cycle
   // and match it against the oldest outstanding transaction.
   always @(posedge clock) begin : result_check
      breaker_outcome_type want;
      if (!reset && rsp_valid) begin
         if (pend_wr == pend_rd) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want    = pending_fifo[pend_rd % PENDING_DEPTH];
            pend_rd = pend_rd + 1;
            check_field("allowed",       32'(rsp_allowed),       32'(want.allowed),
                        want);
            check_field("circuit_state", 32'(rsp_circuit_state), 32'(want.state),
                        want);
            check_field("is_open",       32'(rsp_is_open),       32'(want.is_open),
                        want);
            check_field("is_available",  32'(rsp_is_available),  32'(want.is_available),
                        want);
         end
      end
   end

   // Watchdog: any accepted transaction, result or register access restarts it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Register access: write, then read back in the same select window
   // -------------------------------------------------------------------------
   task automatic csr_access(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] got;
      mask = (idx == REG_WINDOW_MS) ? 32'h0000_3FFF : 32'h0000_FFFF;
      // Setup phase; junk in the unused upper bits must be ignored.
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= (value & mask) | ($urandom() & ~mask);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // Keep psel up and go straight into the read-back setup phase.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if ((got & mask) !== (value & mask))
         report_mismatch($sformatf("register %0d read %h want %h", idx, got & mask,
                                   value & mask));
      case (idx)
         REG_MIN_REQUESTS:    cfg_min      = value & mask;
         REG_ERROR_THRESHOLD: cfg_thr      = value & mask;
         REG_WINDOW_MS:       cfg_window   = value & mask;
         REG_BASE_ISOLATION:  cfg_base_iso = value & mask;
         REG_MAX_ISOLATION:   cfg_max_iso  = value & mask;
         default: ;
      endcase
   endtask

   task automatic apply_config(input breaker_cfg_type c);
      csr_access(REG_MIN_REQUESTS,    c.min_req);
      csr_access(REG_ERROR_THRESHOLD, c.thr);
      csr_access(REG_WINDOW_MS,       c.window);
      csr_access(REG_BASE_ISOLATION,  c.base_iso);
      csr_access(REG_MAX_ISOLATION,   c.max_iso);
   endtask

   // -------------------------------------------------------------------------
   // Command channel
   // -------------------------------------------------------------------------
   // Hold start until the transaction is taken, then predict its result.
   task automatic send_transaction(input cmd_type cmd, input logic [31:0] now,
                                   input stim_row_type row);
      breaker_outcome_type res;
      req_command <= cmd;
      req_now_ms  <= now;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      predict_breaker(cmd, now, res);
      if (row.fixed) begin
         res.allowed      = row.allowed;
         res.state        = row.state;
         res.is_open      = row.is_open;
         res.is_available = row.is_available;
      end
      if (pend_wr - pend_rd >= PENDING_DEPTH)
         report_mismatch("too many transactions outstanding");
      pending_fifo[pend_wr % PENDING_DEPTH] = res;
      pend_wr = pend_wr + 1;
   endtask

   // Drop start and hold until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pend_wr != pend_rd)
         @(posedge clock);
   endtask

   task automatic settle_idle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // While half-open, mostly follow the probe with its outcome report.
   function automatic cmd_type pick_command(input int err_pct);
      int r;
      r = $urandom_range(0, 99);
      if (brk_mode == MODE_HALF && r < 70)
         return ($urandom_range(0, 1) != 0) ? CMD_ERROR : CMD_SUCCESS;
      r = $urandom_range(0, 99);
      if (r < 35) return CMD_REQUEST;
      if (r < 45) return CMD_STATUS;
      return ($urandom_range(1, 100) <= err_pct) ? CMD_ERROR : CMD_SUCCESS;
   endfunction

   // While open, often land right on the end of isolation (one ms either
   // side); otherwise walk time forward with an occasional arbitrary jump.
   function automatic logic [31:0] next_time(input logic [31:0] now, input logic slow);
      int r;
      r = $urandom_range(0, 99);
      if (brk_mode == MODE_OPEN && r < 35)
         return opened_ms + iso_ms + $urandom_range(0, 2) - 1;
      if (slow)
         return (r < 80) ? now + $urandom_range(900, 1100) : now + $urandom_range(0, 400);
      if (r < 65) return now + $urandom_range(0, 60);
      if (r < 88) return now + $urandom_range(900, 1100);
      if (r < 97) return now + $urandom_range(1100, 20000);
      return $urandom();
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   // Directed walk under a small trip count: trip, refusal while open, the
   // isolation boundary, probe, failed probe with capped doubling, successful
   // probe, the exact-equality trip boundary and time wrapping past 2^32.
   localparam breaker_cfg_type DIRECTED_CFG =
      '{32'd2, 32'h8000, 32'd3000, 32'd50, 32'd120, 1'b0};

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{CMD_STATUS,  32'd0,          1'b1, 1'b0, MODE_CLOSED, 1'b0, 1'b1},
      '{CMD_REQUEST, 32'd0,          1'b1, 1'b1, MODE_CLOSED, 1'b0, 1'b1},
      '{CMD_ERROR,   32'd10,         1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_ERROR,   32'd20,         1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd30,         1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd40,         1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_STATUS,  32'd129,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_STATUS,  32'd130,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_SUCCESS, 32'd131,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd130,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd140,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_ERROR,   32'd150,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd269,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd270,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_ERROR,   32'd270,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd390,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_SUCCESS, 32'd400,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'd410,        1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_SUCCESS, 32'hFFFF_FFFF,  1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_ERROR,   32'h0000_0005,  1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'h0000_0010,  1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_ERROR,   32'h0000_0020,  1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_REQUEST, 32'h0000_0030,  1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_STATUS,  32'h7FFF_FFFF,  1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0},
      '{CMD_STATUS,  32'h8000_0000,  1'b0, 1'b0, MODE_CLOSED, 1'b0, 1'b0}
   };

   // Register settings for the random part: ordinary, mostly minimum,
   // all-maximum, out of range (zero window and isolation), a full ring at
   // one slice per transaction, a cap below the base, and the reset values.
   breaker_cfg_type phase_cfgs [NUM_PHASES] = '{
      '{32'd4,     32'h8000, 32'd5000,  32'd50,    32'd400,   1'b0},
      '{32'd0,     32'h0000, 32'd1000,  32'd1,     32'd65535, 1'b0},
      '{32'd65535, 32'hFFFF, 32'd16383, 32'd65535, 32'd65535, 1'b0},
      '{32'd3,     32'h4000, 32'd0,     32'd0,     32'd0,     1'b0},
      '{32'd8,     32'hC000, 32'd16383, 32'd200,   32'd1000,  1'b1},
      '{32'd1,     32'hFFFF, 32'd2000,  32'd30000, 32'd1,     1'b0},
      '{32'd20,    32'h8000, 32'd10000, 32'd100,   32'd30000, 1'b0}
   };

   initial begin : stimulus
      stim_row_type row;
      logic [31:0]  now;
      int           err_pct;
      int           gap;
      logic         gaps_on;
      err_pct = 50;
      gaps_on = 1'b1;
      // Hold reset once at the start, then release it.
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_config(DIRECTED_CFG);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_rows[i];
         send_transaction(row.cmd, row.now_ms, row);
         gap = pick_gap();
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      row = '0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         // Registers change only with the block idle and nothing outstanding.
         settle_idle();
         apply_config(phase_cfgs[p]);
         now = $urandom();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Reshape the error mix and the idling every few dozen transactions.
            if (i % 40 == 0) begin
               err_pct = $urandom_range(0, 100);
               gaps_on = ($urandom_range(0, 3) != 0);
            end
            now = next_time(now, phase_cfgs[p].slow);
            send_transaction(pick_command(err_pct), now, row);
            if ($urandom_range(0, 149) == 0) begin
               drain_results();
            end else if (gaps_on) begin
               gap = pick_gap();
               if (gap > 0) begin
                  start <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      settle_idle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/cbsw_pkg.sv
rtl/core/cbsw_ram.sv
rtl/core/cbsw_window.sv
rtl/core/circuit_breaker_sliding_window_unit.sv
sim/circuit_breaker_sliding_window_unit_tb.sv
